// ----- design/acm_pkg.sv -----
// Shared constants, request/result types and trie row helpers for the matcher.
package acm_pkg;

    localparam int MAX_NODES    = 4096;
    localparam int ALPHABET     = 26;
    localparam int MAX_PATTERNS = 1023;
    localparam int MAX_PAT_LEN  = 32;
    localparam int MAX_RESULTS  = 32;

    localparam int NODE_W = 12;
    localparam int SYM_W  = 5;
    localparam int PID_W  = 10;
    localparam int LEN_W  = 6;
    localparam int CNT_W  = 13;
    localparam int NPID_W = 11;
    localparam int RES_W  = 5;
    localparam int ROW_W  = ALPHABET * NODE_W;
    localparam int LINK_W = 2 * NODE_W;

    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_PATTERN = 2'd1;
    localparam logic [1:0] REQ_BUILD   = 2'd2;
    localparam logic [1:0] REQ_TEXT    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NODE_FULL = 2'd1;
    localparam logic [1:0] ST_PAT_FULL  = 2'd2;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [ROW_W-1:0]  row_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [SYM_W-1:0] symbol;
        logic             word_end;
        logic             restart;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             match_valid;
        logic [PID_W-1:0] pattern_id;
        logic [LEN_W-1:0] pattern_length;
        logic             last;
    } res_t;

    function automatic node_t row_get(row_t row, logic [SYM_W-1:0] c);
        return row[c*NODE_W +: NODE_W];
    endfunction

    function automatic row_t row_put(row_t row, logic [SYM_W-1:0] c, node_t v);
        row_t r;
        r = row;
        r[c*NODE_W +: NODE_W] = v;
        return r;
    endfunction

endpackage

// ----- design/acm_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/aho_corasick_matcher_top.sv -----
// Aho-Corasick matcher: trie insert, breadth-first link build and text scan.
// Text symbol: the first result follows the goto row read, the node read and the pattern
// length read, or is an empty result with no match; further matches repeat the last two reads.
// Pattern symbol: an extra state zeroes a new node when one is created. Clear: zeroes the root.
// Build: queue the root's children, then complete each queued node's row and fail links.
// Reset: one cycle after reset zeroes the root entry before the first request is taken.
module aho_corasick_matcher_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  acm_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_stall,
    output acm_pkg::res_t res_data
);
    import acm_pkg::*;

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_CLR    = 5'd2;
    localparam logic [4:0] S_PEVAL  = 5'd3;
    localparam logic [4:0] S_PNEW   = 5'd4;
    localparam logic [4:0] S_PFIN   = 5'd5;
    localparam logic [4:0] S_B0     = 5'd6;
    localparam logic [4:0] S_BRC    = 5'd7;
    localparam logic [4:0] S_BRS    = 5'd8;
    localparam logic [4:0] S_BPOP   = 5'd9;
    localparam logic [4:0] S_BQ     = 5'd10;
    localparam logic [4:0] S_BR     = 5'd11;
    localparam logic [4:0] S_BF     = 5'd12;
    localparam logic [4:0] S_BC     = 5'd13;
    localparam logic [4:0] S_BL     = 5'd14;
    localparam logic [4:0] S_BWB    = 5'd15;
    localparam logic [4:0] S_BDONE  = 5'd16;
    localparam logic [4:0] S_TGO    = 5'd17;
    localparam logic [4:0] S_TP     = 5'd18;
    localparam logic [4:0] S_TCD    = 5'd19;
    localparam logic [4:0] S_TLEN   = 5'd20;
    localparam logic [4:0] S_TEMPTY = 5'd21;

    localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(ALPHABET - 1);

    // memory ports
    logic              row_we;
    node_t             row_waddr, row_raddr;
    row_t              row_wdata, row_rd;
    logic              pat_we;
    node_t             pat_waddr, pat_raddr;
    logic [PID_W-1:0]  pat_wdata, pat_rd;
    logic              link_we;
    node_t             link_waddr, link_raddr;
    logic [LINK_W-1:0] link_wdata, link_rd;
    logic              len_we;
    logic [PID_W-1:0]  len_waddr, len_raddr;
    logic [LEN_W-1:0]  len_wdata, len_rd;
    logic              q_we;
    node_t             q_waddr, q_raddr, q_wdata, q_rd;

    acm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_row (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rd)
    );
    acm_ram #(.WIDTH(PID_W), .DEPTH(MAX_NODES)) u_pat (
        .clk(clk), .we(pat_we), .waddr(pat_waddr), .wdata(pat_wdata),
        .raddr(pat_raddr), .rdata(pat_rd)
    );
    acm_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rd)
    );
    acm_ram #(.WIDTH(LEN_W), .DEPTH(MAX_PATTERNS + 1)) u_len (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .raddr(len_raddr), .rdata(len_rd)
    );
    acm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rd)
    );

    logic [4:0]        state_reg, state_next;
    req_t              item_reg, item_next;
    logic [CNT_W-1:0]  node_count_reg, node_count_next;
    logic [NPID_W-1:0] npid_reg, npid_next;
    node_t             cursor_reg, cursor_next;
    node_t             match_reg, match_next;
    logic [LEN_W-1:0]  wlen_reg, wlen_next;
    logic              werr_reg, werr_next;
    logic              built_reg, built_next;
    node_t             head_reg, head_next;
    node_t             tail_reg, tail_next;
    logic [SYM_W-1:0]  c_reg, c_next;
    node_t             r_reg, r_next;
    node_t             u_reg, u_next;
    node_t             fu_reg, fu_next;
    node_t             nxtp_reg, nxtp_next;
    logic [PID_W-1:0]  id_reg, id_next;
    logic [RES_W-1:0]  cnt_reg, cnt_next;
    row_t              rowr_reg, rowr_next;
    row_t              rowf_reg, rowf_next;
    logic              res_valid_reg;
    res_t              res_data_reg;

    logic   out_free;
    logic   emit;
    res_t   emit_data;
    logic   accept;
    node_t  ent, fent, pnode;
    logic   sym_ok;

    assign out_free  = !res_valid_reg || !res_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        node_count_next = node_count_reg;
        npid_next       = npid_reg;
        cursor_next     = cursor_reg;
        match_next      = match_reg;
        wlen_next       = wlen_reg;
        werr_next       = werr_reg;
        built_next      = built_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        c_next          = c_reg;
        r_next          = r_reg;
        u_next          = u_reg;
        fu_next         = fu_reg;
        nxtp_next       = nxtp_reg;
        id_next         = id_reg;
        cnt_next        = cnt_reg;
        rowr_next       = rowr_reg;
        rowf_next       = rowf_reg;

        row_we = 1'b0; row_waddr = '0; row_wdata = '0; row_raddr = '0;
        pat_we = 1'b0; pat_waddr = '0; pat_wdata = '0; pat_raddr = '0;
        link_we = 1'b0; link_waddr = '0; link_wdata = '0; link_raddr = '0;
        len_we = 1'b0; len_waddr = '0; len_wdata = '0; len_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

        emit      = 1'b0;
        emit_data = '0;
        sym_ok    = (item_reg.symbol < SYM_W'(ALPHABET));
        ent       = row_get(rowr_reg, c_reg);
        fent      = row_get(rowf_reg, c_reg);
        pnode     = '0;

        unique case (state_reg)
            S_INIT, S_CLR:
            begin
                // zero the root and restart the dictionary
                row_we  = 1'b1;
                pat_we  = 1'b1;
                link_we = 1'b1;
                node_count_next = CNT_W'(1);
                npid_next   = NPID_W'(1);
                cursor_next = '0;
                match_next  = '0;
                wlen_next   = '0;
                werr_next   = 1'b0;
                built_next  = 1'b0;
                if (state_reg == S_INIT)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = req_data;
                    unique case (req_data.req_type)
                        REQ_CLEAR:   state_next = S_CLR;
                        REQ_PATTERN:
                        begin
                            row_raddr  = cursor_reg;
                            state_next = built_reg ? S_PFIN : S_PEVAL;
                        end
                        REQ_BUILD:   state_next = built_reg ? S_BDONE : S_B0;
                        REQ_TEXT:
                        begin
                            row_raddr  = req_data.restart ? '0 : match_reg;
                            match_next = row_raddr;
                            state_next = S_TGO;
                        end
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_PEVAL:
            begin
                state_next = S_PFIN;
                if (sym_ok && !werr_reg && wlen_reg < LEN_W'(MAX_PAT_LEN))
                begin
                    if (row_get(row_rd, item_reg.symbol) == '0)
                    begin
                        if (node_count_reg >= CNT_W'(MAX_NODES))
                        begin
                            werr_next = 1'b1;
                        end
                        else
                        begin
                            // hang the new node under the cursor, zero it next
                            row_we    = 1'b1;
                            row_waddr = cursor_reg;
                            row_wdata = row_put(row_rd, item_reg.symbol,
                                                node_count_reg[NODE_W-1:0]);
                            cursor_next     = node_count_reg[NODE_W-1:0];
                            node_count_next = node_count_reg + CNT_W'(1);
                            wlen_next       = wlen_reg + LEN_W'(1);
                            state_next      = S_PNEW;
                        end
                    end
                    else
                    begin
                        cursor_next = row_get(row_rd, item_reg.symbol);
                        wlen_next   = wlen_reg + LEN_W'(1);
                    end
                end
            end
            S_PNEW:
            begin
                row_we = 1'b1; row_waddr = cursor_reg;
                pat_we = 1'b1; pat_waddr = cursor_reg;
                link_we = 1'b1; link_waddr = cursor_reg;
                state_next = S_PFIN;
            end
            S_PFIN:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.last = 1'b1;
                    state_next = S_IDLE;
                    if (!built_reg)
                    begin
                        emit_data.status = werr_reg ? ST_NODE_FULL : ST_OK;
                        if (item_reg.word_end)
                        begin
                            if (!werr_reg && wlen_reg != '0)
                            begin
                                if (npid_reg > NPID_W'(MAX_PATTERNS))
                                begin
                                    emit_data.status = ST_PAT_FULL;
                                end
                                else
                                begin
                                    pat_we    = 1'b1;
                                    pat_waddr = cursor_reg;
                                    pat_wdata = npid_reg[PID_W-1:0];
                                    len_we    = 1'b1;
                                    len_waddr = npid_reg[PID_W-1:0];
                                    len_wdata = wlen_reg;
                                    emit_data.pattern_id     = npid_reg[PID_W-1:0];
                                    emit_data.pattern_length = wlen_reg;
                                    npid_next = npid_reg + NPID_W'(1);
                                end
                            end
                            cursor_next = '0;
                            wlen_next   = '0;
                            werr_next   = 1'b0;
                        end
                    end
                end
            end
            S_B0:
            begin
                link_we    = 1'b1;
                row_raddr  = '0;
                head_next  = '0;
                tail_next  = '0;
                state_next = S_BRC;
            end
            S_BRC:
            begin
                rowr_next  = row_rd;
                c_next     = '0;
                state_next = S_BRS;
            end
            S_BRS:
            begin
                // children of the root fail to the root
                if (ent != '0)
                begin
                    link_we    = 1'b1;
                    link_waddr = ent;
                    q_we       = 1'b1;
                    q_waddr    = tail_reg;
                    q_wdata    = ent;
                    tail_next  = tail_reg + NODE_W'(1);
                end
                c_next = c_reg + SYM_W'(1);
                if (c_reg == LAST_SYM)
                begin
                    state_next = S_BPOP;
                end
            end
            S_BPOP:
            begin
                q_raddr = head_reg;
                if (head_reg == tail_reg)
                begin
                    state_next = S_BDONE;
                end
                else
                begin
                    head_next  = head_reg + NODE_W'(1);
                    state_next = S_BQ;
                end
            end
            S_BQ:
            begin
                r_next     = q_rd;
                row_raddr  = q_rd;
                link_raddr = q_rd;
                state_next = S_BR;
            end
            S_BR:
            begin
                rowr_next  = row_rd;
                row_raddr  = link_rd[LINK_W-1:NODE_W];
                state_next = S_BF;
            end
            S_BF:
            begin
                rowf_next  = row_rd;
                c_next     = '0;
                state_next = S_BC;
            end
            S_BC:
            begin
                if (ent == '0)
                begin
                    // complete the missing edge from the fail node
                    rowr_next = row_put(rowr_reg, c_reg, fent);
                    c_next    = c_reg + SYM_W'(1);
                    if (c_reg == LAST_SYM)
                    begin
                        state_next = S_BWB;
                    end
                end
                else
                begin
                    q_we       = 1'b1;
                    q_waddr    = tail_reg;
                    q_wdata    = ent;
                    tail_next  = tail_reg + NODE_W'(1);
                    u_next     = ent;
                    fu_next    = fent;
                    pat_raddr  = fent;
                    link_raddr = fent;
                    state_next = S_BL;
                end
            end
            S_BL:
            begin
                link_we    = 1'b1;
                link_waddr = u_reg;
                link_wdata = {fu_reg, (pat_rd != '0) ? fu_reg : link_rd[NODE_W-1:0]};
                c_next     = c_reg + SYM_W'(1);
                state_next = (c_reg == LAST_SYM) ? S_BWB : S_BC;
            end
            S_BWB:
            begin
                row_we     = 1'b1;
                row_waddr  = r_reg;
                row_wdata  = rowr_reg;
                state_next = S_BPOP;
            end
            S_BDONE:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.last = 1'b1;
                    built_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TGO:
            begin
                match_next = sym_ok ? row_get(row_rd, item_reg.symbol) : '0;
                pat_raddr  = match_next;
                link_raddr = match_next;
                state_next = S_TP;
            end
            S_TP:
            begin
                pnode = (pat_rd != '0) ? match_reg : link_rd[NODE_W-1:0];
                cnt_next = '0;
                if (pnode == '0)
                begin
                    state_next = S_TEMPTY;
                end
                else
                begin
                    pat_raddr  = pnode;
                    link_raddr = pnode;
                    state_next = S_TCD;
                end
            end
            S_TCD:
            begin
                id_next    = pat_rd;
                nxtp_next  = link_rd[NODE_W-1:0];
                len_raddr  = pat_rd;
                state_next = S_TLEN;
            end
            S_TLEN:
            begin
                // hold the length read until the result register frees up
                len_raddr = id_reg;
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.match_valid    = 1'b1;
                    emit_data.pattern_id     = id_reg;
                    emit_data.pattern_length = len_rd;
                    emit_data.last = (nxtp_reg == '0) || (cnt_reg == RES_W'(MAX_RESULTS - 1));
                    if (emit_data.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + RES_W'(1);
                        pat_raddr  = nxtp_reg;
                        link_raddr = nxtp_reg;
                        state_next = S_TCD;
                    end
                end
            end
            S_TEMPTY:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            node_count_reg <= CNT_W'(1);
            npid_reg       <= NPID_W'(1);
            cursor_reg     <= '0;
            match_reg      <= '0;
            wlen_reg       <= '0;
            werr_reg       <= 1'b0;
            built_reg      <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            c_reg          <= '0;
            cnt_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            npid_reg       <= npid_next;
            cursor_reg     <= cursor_next;
            match_reg      <= match_next;
            wlen_reg       <= wlen_next;
            werr_reg       <= werr_next;
            built_reg      <= built_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            c_reg          <= c_next;
            cnt_reg        <= cnt_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        r_reg    <= r_next;
        u_reg    <= u_next;
        fu_reg   <= fu_next;
        nxtp_reg <= nxtp_next;
        id_reg   <= id_next;
        rowr_reg <= rowr_next;
        rowf_reg <= rowf_next;
        if (emit)
        begin
            res_data_reg <= emit_data;
        end
    end

endmodule
